@@ hw/rtl/priority_queue_max_remove_assert.svh @@
// Assertion macros for the priority queue RTL.
`ifndef PRIORITY_QUEUE_MAX_REMOVE_ASSERT_SVH
`define PRIORITY_QUEUE_MAX_REMOVE_ASSERT_SVH
`ifndef SYNTH
`define PQ_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pqmr check failed");
`define PQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pqmr check failed");
`else
`define PQ_ASSERT(lbl, clk, rst_n, ante, cons)
`define PQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/pqmr_pkg.sv @@
// Shared types and constants of the priority queue.
`default_nettype none

package pqmr_pkg;

    localparam int HANDLE_W    = 16;
    localparam int PRIO_IN_W   = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 6;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_PUT,
        S_REM_HEAD,
        S_REM_SHIFT,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/pqmr_chan_if.sv @@
// Request and result channel interfaces of the priority queue.
`default_nettype none

interface pqmr_req_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [pqmr_pkg::PRIO_IN_W-1:0] priority_req;
    logic [pqmr_pkg::HANDLE_W-1:0]  handle;

    modport source (output valid, action, priority_req, handle, input ready);
    modport sink   (input valid, action, priority_req, handle, output ready);
endinterface

interface pqmr_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pqmr_pkg::STATUS_W-1:0]    status;
    logic [pqmr_pkg::HANDLE_W-1:0]    out_handle;
    logic [pqmr_pkg::PRIO_IN_W-1:0]   out_priority;
    logic [pqmr_pkg::COUNT_OUT_W-1:0] live_count;

    modport source (output valid, status, out_handle, out_priority, live_count, input ready);
    modport sink   (input valid, status, out_handle, out_priority, live_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pqmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pqmr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/priority_queue_max_remove.sv @@
// Bounded max-priority queue kept sorted in one RAM; top level.
// Insert: one descending RAM pass shifting entries up.
// Remove: one ascending RAM pass shifting entries down.
// Full or empty cases skip the RAM pass; one request in work at a time, the
// result register lets the next request enter while a result waits.
// Reset: synchronous active-low, clears count, state and result valid.
`default_nettype none
`include "priority_queue_max_remove_assert.svh"

module priority_queue_max_remove #(
    parameter int ENTRIES       = 32,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pqmr_req_if.sink    i_req,
    pqmr_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int PW = PRIORITY_BITS;
    localparam int HW = pqmr_pkg::HANDLE_W;
    localparam int DW = PW + HW;
    localparam int IW = pqmr_pkg::PRIO_IN_W;
    localparam int OW = pqmr_pkg::COUNT_OUT_W;

    pqmr_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_act, n_act;
    logic [PW-1:0] r_pri, n_pri;
    logic [HW-1:0] r_hnd, n_hnd;
    logic [1:0]    r_status, n_status;
    logic [PW-1:0] r_rm_pri, n_rm_pri;
    logic [HW-1:0] r_rm_hnd, n_rm_hnd;

    logic          r_ov, n_ov;
    logic [1:0]    r_ost, n_ost;
    logic [HW-1:0] r_ohnd, n_ohnd;
    logic [IW-1:0] r_opri, n_opri;
    logic [OW-1:0] r_ocnt, n_ocnt;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rd_data;
    logic [PW-1:0] rd_pri;
    logic [HW-1:0] rd_hnd;

    logic          acc, out_free, out_load;
    logic          is_full, is_empty, rd_lower, idx_last;
    logic [CW-1:0] c_last, idx_w, cnt_next;
    logic [PW-1:0] pri_in;
    logic [PW+IW-1:0] pri_in_ext;
    logic [PW+IW-1:0] pri_out_ext;
    logic [CW+OW-1:0] cnt_ext;

    pqmr_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign acc         = i_req.valid && i_req.ready;
    assign out_free    = !r_ov || o_rsp.ready;
    assign out_load    = (r_state == pqmr_pkg::S_FIN) && out_free;
    assign is_full     = (r_count == CW'(ENTRIES));
    assign is_empty    = (r_count == '0);
    assign c_last      = r_count - CW'(1);
    assign idx_w       = CW'(r_idx);
    assign idx_last    = (idx_w == c_last);
    assign rd_pri      = rd_data[DW-1:HW];
    assign rd_hnd      = rd_data[HW-1:0];
    assign rd_lower    = (rd_pri < r_pri);
    assign pri_in_ext  = {{PW{1'b0}}, i_req.priority_req};
    assign pri_in      = pri_in_ext[PW-1:0];
    assign pri_out_ext = {{IW{1'b0}}, r_rm_pri};

    always_comb begin
        cnt_next = r_count;
        if (r_status == pqmr_pkg::ST_DONE) begin
            if (r_act == pqmr_pkg::ACT_INSERT) begin
                cnt_next = r_count + CW'(1);
            end else begin
                cnt_next = r_count - CW'(1);
            end
        end
    end

    assign cnt_ext = {{OW{1'b0}}, cnt_next};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pqmr_pkg::S_IDLE: begin
                if (acc) begin
                    if (i_req.action == pqmr_pkg::ACT_INSERT) begin
                        n_state = (is_full || is_empty) ? pqmr_pkg::S_FIN : pqmr_pkg::S_INS;
                    end else begin
                        n_state = is_empty ? pqmr_pkg::S_FIN : pqmr_pkg::S_REM_HEAD;
                    end
                end
            end
            pqmr_pkg::S_INS: begin
                if (!rd_lower) begin
                    n_state = pqmr_pkg::S_FIN;
                end else if (r_idx == '0) begin
                    n_state = pqmr_pkg::S_INS_PUT;
                end
            end
            pqmr_pkg::S_INS_PUT: begin
                n_state = pqmr_pkg::S_FIN;
            end
            pqmr_pkg::S_REM_HEAD: begin
                n_state = (r_count == CW'(1)) ? pqmr_pkg::S_FIN : pqmr_pkg::S_REM_SHIFT;
            end
            pqmr_pkg::S_REM_SHIFT: begin
                if (idx_last) begin
                    n_state = pqmr_pkg::S_FIN;
                end
            end
            pqmr_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = pqmr_pkg::S_IDLE;
                end
            end
            default: n_state = pqmr_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        i_req.ready = 1'b0;
        we          = 1'b0;
        waddr       = r_idx;
        wdata       = {r_pri, r_hnd};
        raddr       = r_idx;
        n_count     = r_count;
        n_idx       = r_idx;
        n_act       = r_act;
        n_pri       = r_pri;
        n_hnd       = r_hnd;
        n_status    = r_status;
        n_rm_pri    = r_rm_pri;
        n_rm_hnd    = r_rm_hnd;
        case (r_state)
            pqmr_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (acc) begin
                    n_act    = i_req.action;
                    n_pri    = pri_in;
                    n_hnd    = i_req.handle;
                    n_rm_pri = '0;
                    n_rm_hnd = '0;
                    n_status = pqmr_pkg::ST_DONE;
                    if (i_req.action == pqmr_pkg::ACT_INSERT) begin
                        if (is_full) begin
                            n_status = pqmr_pkg::ST_FULL;
                        end else if (is_empty) begin
                            we    = 1'b1;
                            waddr = '0;
                            wdata = {pri_in, i_req.handle};
                        end else begin
                            raddr = AW'(c_last);
                            n_idx = AW'(c_last);
                        end
                    end else begin
                        if (is_empty) begin
                            n_status = pqmr_pkg::ST_EMPTY;
                        end else begin
                            raddr = '0;
                            n_idx = '0;
                        end
                    end
                end
            end
            pqmr_pkg::S_INS: begin
                we    = 1'b1;
                waddr = r_idx + AW'(1);
                if (rd_lower) begin
                    wdata = rd_data;
                    if (r_idx != '0) begin
                        raddr = r_idx - AW'(1);
                        n_idx = r_idx - AW'(1);
                    end
                end
            end
            pqmr_pkg::S_INS_PUT: begin
                we = 1'b1;
            end
            pqmr_pkg::S_REM_HEAD: begin
                n_rm_pri = rd_pri;
                n_rm_hnd = rd_hnd;
                raddr    = AW'(1);
                n_idx    = AW'(1);
            end
            pqmr_pkg::S_REM_SHIFT: begin
                we    = 1'b1;
                waddr = r_idx - AW'(1);
                wdata = rd_data;
                if (!idx_last) begin
                    raddr = r_idx + AW'(1);
                    n_idx = r_idx + AW'(1);
                end
            end
            pqmr_pkg::S_FIN: begin
                if (out_free) begin
                    n_count = cnt_next;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // result register
    always_comb begin
        n_ov   = r_ov;
        n_ost  = r_ost;
        n_ohnd = r_ohnd;
        n_opri = r_opri;
        n_ocnt = r_ocnt;
        if (out_load) begin
            n_ov   = 1'b1;
            n_ost  = r_status;
            n_ohnd = r_rm_hnd;
            n_opri = pri_out_ext[IW-1:0];
            n_ocnt = cnt_ext[OW-1:0];
        end else if (o_rsp.ready) begin
            n_ov = 1'b0;
        end
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.status       = r_ost;
    assign o_rsp.out_handle   = r_ohnd;
    assign o_rsp.out_priority = r_opri;
    assign o_rsp.live_count   = r_ocnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pqmr_pkg::S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_act    <= n_act;
        r_pri    <= n_pri;
        r_hnd    <= n_hnd;
        r_status <= n_status;
        r_rm_pri <= n_rm_pri;
        r_rm_hnd <= n_rm_hnd;
        r_ost    <= n_ost;
        r_ohnd   <= n_ohnd;
        r_opri   <= n_opri;
        r_ocnt   <= n_ocnt;
    end

    `PQ_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(ENTRIES))
    `PQ_ASSERT(a_write_in_range, i_clk, i_rst_n, we, CW'(waddr) <= r_count)
    `PQ_ASSERT(a_load_from_fin, i_clk, i_rst_n, $rose(r_ov), $past(r_state == pqmr_pkg::S_FIN))
    `PQ_ASSERT_NEXT(a_empty_remove_fast, i_clk, i_rst_n, acc && is_empty && (i_req.action == pqmr_pkg::ACT_REMOVE), r_state == pqmr_pkg::S_FIN)
    `PQ_ASSERT(a_busy_not_ready, i_clk, i_rst_n, r_state == pqmr_pkg::S_FIN, !i_req.ready)

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the sorted max-priority queue: random and directed requests.
`default_nettype none

module testbench;

    localparam int QUEUE_DEPTH     = 32;
    localparam int PRIORITY_BITS   = 8;
    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int PHASES          = 4;
    localparam int ITEMS_PER_PHASE = 435;
    localparam int DRAIN_CYCLES    = 64;
    localparam int TIMEOUT_CYCLES  = 600000;
    localparam int MAX_PRINTS      = 40;

    typedef struct {
        logic                           action;
        logic [pqmr_pkg::PRIO_IN_W-1:0] prio;
        logic [pqmr_pkg::HANDLE_W-1:0]  handle;
    } t_pq_request;

    typedef struct {
        logic [pqmr_pkg::STATUS_W-1:0]    status;
        logic [pqmr_pkg::HANDLE_W-1:0]    handle;
        logic [pqmr_pkg::PRIO_IN_W-1:0]   prio;
        logic [pqmr_pkg::COUNT_OUT_W-1:0] count;
    } t_pq_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pqmr_req_if req_if ();
    pqmr_rsp_if rsp_if ();

    priority_queue_max_remove #(
        .ENTRIES      (QUEUE_DEPTH),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_pq_request pending_requests [$];
    t_pq_result  expected_results [$];
    t_pq_request current_request;

    // shadow of the sorted queue: index 0 is served next
    logic [pqmr_pkg::PRIO_IN_W-1:0] sorted_prio   [QUEUE_DEPTH];
    logic [pqmr_pkg::HANDLE_W-1:0]  sorted_handle [QUEUE_DEPTH];
    int held_count = 0;

    int queued_count   = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int error_count    = 0;
    int insert_count   = 0;
    int remove_count   = 0;
    int full_drops     = 0;
    int empty_removes  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int idle_by_phase  [PHASES] = '{0, 71, 0, 10};
    int stall_by_phase [PHASES] = '{0, 0, 71, 10};

    function automatic t_pq_result apply_request(t_pq_request r);
        int pos;
        t_pq_result res;
        res.status = pqmr_pkg::ST_DONE;
        res.handle = '0;
        res.prio   = '0;
        if (r.action == pqmr_pkg::ACT_INSERT) begin
            if (held_count >= QUEUE_DEPTH) begin
                res.status = pqmr_pkg::ST_FULL;
                full_drops++;
            end else begin
                // new entry goes behind all entries of greater or equal priority
                pos = held_count;
                for (int i = held_count - 1; i >= 0; i--) begin
                    if (sorted_prio[i] < r.prio) pos = i;
                end
                for (int i = held_count; i > pos; i--) begin
                    sorted_prio[i]   = sorted_prio[i-1];
                    sorted_handle[i] = sorted_handle[i-1];
                end
                sorted_prio[pos]   = r.prio;
                sorted_handle[pos] = r.handle;
                held_count++;
                insert_count++;
            end
        end else if (held_count == 0) begin
            res.status = pqmr_pkg::ST_EMPTY;
            empty_removes++;
        end else begin
            res.handle = sorted_handle[0];
            res.prio   = sorted_prio[0];
            for (int i = 0; i + 1 < held_count; i++) begin
                sorted_prio[i]   = sorted_prio[i+1];
                sorted_handle[i] = sorted_handle[i+1];
            end
            held_count--;
            remove_count++;
        end
        res.count = held_count[pqmr_pkg::COUNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        if (error_count < MAX_PRINTS)
            $display("error: result %0d %s: got %0h, expected %0h",
                     checked_count, field, got, want);
        error_count++;
    endtask

    task automatic check_result(t_pq_result got);
        t_pq_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, status", int'(got.status), 0);
        end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", int'(got.status), int'(want.status));
            if (got.handle !== want.handle)
                report_mismatch("out_handle", int'(got.handle), int'(want.handle));
            if (got.prio !== want.prio)
                report_mismatch("out_priority", int'(got.prio), int'(want.prio));
            if (got.count !== want.count)
                report_mismatch("live_count", int'(got.count), int'(want.count));
        end
        checked_count++;
    endtask

    task automatic push_request(logic action, logic [pqmr_pkg::PRIO_IN_W-1:0] prio,
                                logic [pqmr_pkg::HANDLE_W-1:0] handle);
        t_pq_request r;
        r.action = action;
        r.prio   = prio;
        r.handle = handle;
        pending_requests.push_back(r);
        queued_count++;
    endtask

    task automatic push_directed();
        push_request(pqmr_pkg::ACT_REMOVE, 8'h00, 16'h0000);   // remove on empty
        push_request(pqmr_pkg::ACT_INSERT, 8'h00, 16'h0000);
        push_request(pqmr_pkg::ACT_INSERT, 8'hff, 16'hffff);
        push_request(pqmr_pkg::ACT_INSERT, 8'hff, 16'h0001);   // tie at the head
        push_request(pqmr_pkg::ACT_INSERT, 8'h80, 16'h5a5a);
        push_request(pqmr_pkg::ACT_INSERT, 8'h00, 16'ha5a5);   // tie at the tail
        push_request(pqmr_pkg::ACT_INSERT, 8'h80, 16'h1234);   // tie in the middle
        repeat (7) push_request(pqmr_pkg::ACT_REMOVE, 8'hff, 16'hffff);
        push_request(pqmr_pkg::ACT_INSERT, 8'h7f, 16'h0011);
        push_request(pqmr_pkg::ACT_INSERT, 8'h7f, 16'h0022);
        push_request(pqmr_pkg::ACT_INSERT, 8'h7f, 16'h0033);
        repeat (3) push_request(pqmr_pkg::ACT_REMOVE, 8'h55, 16'haaaa);
    endtask

    task automatic push_random(int n);
        int run_left;
        int insert_pct;
        logic action;
        logic [pqmr_pkg::PRIO_IN_W-1:0] prio;
        logic [pqmr_pkg::HANDLE_W-1:0] handle;
        run_left = 0;
        insert_pct = 50;
        for (int k = 0; k < n; k++) begin
            // runs biased toward filling or draining so full and empty both occur often
            if (run_left == 0) begin
                run_left = int'($urandom_range(10, 60));
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            run_left--;
            action = ($urandom_range(0, 99) < insert_pct) ? pqmr_pkg::ACT_INSERT
                                                          : pqmr_pkg::ACT_REMOVE;
            case ($urandom_range(0, 3))
                1: prio = pqmr_pkg::PRIO_IN_W'($urandom_range(0, 3));
                2: prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
                default: prio = pqmr_pkg::PRIO_IN_W'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 15) == 0)
                handle = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            else
                handle = pqmr_pkg::HANDLE_W'($urandom_range(0, 65535));
            push_request(action, prio, handle);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_results.push_back(apply_request(current_request));
                accepted_count++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    current_request = pending_requests.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.action       <= current_request.action;
                    req_if.priority_req <= current_request.prio;
                    req_if.handle       <= current_request.handle;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_pq_result got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.status = rsp_if.status;
                got.handle = rsp_if.out_handle;
                got.prio   = rsp_if.out_priority;
                got.count  = rsp_if.live_count;
                check_result(got);
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("priority_queue_max_remove: mismatch");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.action       = pqmr_pkg::ACT_INSERT;
        req_if.priority_req = '0;
        req_if.handle       = '0;
        rsp_if.ready        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            if (phase == 0) push_directed();
            push_random(ITEMS_PER_PHASE);
            while (accepted_count != queued_count || expected_results.size() != 0)
                @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests checked over %0d idle/stall phases", checked_count, PHASES);
        $display("%0d inserts, %0d removes, %0d dropped on full, %0d removes on empty",
                 insert_count, remove_count, full_drops, empty_removes);
        if (error_count == 0)
            $display("priority_queue_max_remove: match");
        else
            $display("priority_queue_max_remove: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pqmr_pkg.sv
hw/rtl/pqmr_chan_if.sv
hw/rtl/pqmr_ram.sv
hw/rtl/priority_queue_max_remove.sv
tb/sv/testbench.sv
